/* hw/rtl/rpn_stack_calculator_assert.svh */
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Clocked assertion helpers shared by the calculator RTL.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define RPN_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define RPN_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Command and result transaction types, command and status codes, states.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // Command codes; codes six and seven are accepted and do nothing.
    localparam logic [2:0] FUNC_PUSH = 3'd0;
    localparam logic [2:0] FUNC_ADD  = 3'd1;
    localparam logic [2:0] FUNC_SUB  = 3'd2;
    localparam logic [2:0] FUNC_MUL  = 3'd3;
    localparam logic [2:0] FUNC_DIV  = 3'd4;
    localparam logic [2:0] FUNC_SHOW = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [2:0] STAT_DIV_ZERO  = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [31:0]  operand;
    } cmd_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  top_value;
        logic [7:0]          depth;
        logic                saturated;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_COMMIT,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/rpn_stack_calculator.sv */
// Before the done strobe every transaction passes through FINISH: push, show,
// unused codes and errors other than divide by zero go there directly; divide by
// zero passes EXEC first; add and subtract pass EXEC and COMMIT; multiply passes
// EXEC, MUL and COMMIT; and divide (Q16.16 operands by default) passes EXEC, DIV,
// DIVFIX and COMMIT, the one-bit-per-cycle divider iterating in DIV. A new transaction is taken during the done cycle.
// Reset empties the stack at once; the stack memory itself is not cleared.
`include "rpn_stack_calculator_assert.svh"
// ----------------------------------------------------------------------------
// RPN stack calculator
// Q16.16 fixed-point stack machine with saturating add, subtract, multiply
// and divide, kept in a single-port-write, registered-read stack memory.
// ----------------------------------------------------------------------------
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int FRAC_BITS   = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DIV_W  = 32 + FRAC_BITS;
    localparam int ITER_W = $clog2(DIV_W + 1);

    // Stack memory: entries below count_reg are live; the top is also cached.
    logic [31:0] stack_mem [STACK_DEPTH];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic signed [31:0]  top_reg, top_next;
    logic [2:0]          func_reg, func_next;
    logic [2:0]          status_reg, status_next;
    logic                sat_reg, sat_next;
    logic signed [31:0]  res_reg, res_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic [DIV_W-1:0]    dvd_reg, dvd_next;
    logic [32:0]         rem_reg, rem_next;
    logic [31:0]         dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                done_reg;
    result_t             result_reg;

    logic signed [31:0]  rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata;

    logic                accept;
    logic                is_binary;
    logic [CNT_W-1:0]    cnt_m2;
    logic signed [31:0]  a_op, b_op;
    logic [32:0]         sum_ext, diff_ext;
    logic signed [63:0]  mul_full, mul_shift;
    logic [31:0]         mag_a, mag_b;
    logic [32:0]         trial;
    logic                trial_ge;
    logic [DIV_W:0]      quot_ext;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign is_binary = (cmd.func inside {FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV});
    assign cnt_m2    = count_reg - CNT_W'(2);

    // First operand comes from memory, second is the cached top.
    assign a_op     = rd_data_reg;
    assign b_op     = top_reg;
    assign sum_ext  = {a_op[31], a_op} + {b_op[31], b_op};
    assign diff_ext = {a_op[31], a_op} - {b_op[31], b_op};
    assign mul_full = a_op * b_op;
    // Arithmetic shift gives the floor of the scaled product.
    assign mul_shift = prod_reg >>> FRAC_BITS;
    assign mag_a    = a_op[31] ? (~a_op + 32'd1) : a_op;
    assign mag_b    = b_op[31] ? (~b_op + 32'd1) : b_op;
    assign trial    = {rem_reg[31:0], dvd_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});
    assign quot_ext = {1'b0, dvd_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_binary && (count_reg >= CNT_W'(2)))
                        state_next = ST_EXEC;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_EXEC:
            begin
                if (func_reg == FUNC_MUL)
                    state_next = ST_MUL;
                else if (func_reg == FUNC_DIV)
                    state_next = (b_op == 32'sd0) ? ST_FINISH : ST_DIV;
                else
                    state_next = ST_COMMIT;
            end
            ST_MUL:    state_next = ST_COMMIT;
            ST_DIV:
            begin
                if (iter_reg == ITER_W'(1))
                    state_next = ST_DIVFIX;
            end
            ST_DIVFIX: state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        func_next   = func_reg;
        status_next = status_reg;
        sat_next    = sat_reg;
        res_next    = res_reg;
        prod_next   = prod_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        iter_next   = iter_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = count_reg[ADDR_W-1:0];
        mem_raddr   = cnt_m2[ADDR_W-1:0];
        mem_wdata   = cmd.operand;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = cmd.func;
                    status_next = STAT_OK;
                    sat_next    = 1'b0;
                    if (cmd.func == FUNC_PUSH)
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                            status_next = STAT_OVERFLOW;
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            top_next   = cmd.operand;
                        end
                    end
                    else if (is_binary)
                    begin
                        if (count_reg < CNT_W'(2))
                            status_next = STAT_UNDERFLOW;
                        else
                            mem_re = 1'b1;
                    end
                    else if (cmd.func == FUNC_SHOW)
                    begin
                        if (count_reg == '0)
                            status_next = STAT_EMPTY;
                    end
                end
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_ADD:
                    begin
                        res_next = sum_ext[31:0];
                        if (sum_ext[32] != sum_ext[31])
                        begin
                            sat_next = 1'b1;
                            res_next = sum_ext[32] ? Q_MIN : Q_MAX;
                        end
                    end
                    FUNC_SUB:
                    begin
                        res_next = diff_ext[31:0];
                        if (diff_ext[32] != diff_ext[31])
                        begin
                            sat_next = 1'b1;
                            res_next = diff_ext[32] ? Q_MIN : Q_MAX;
                        end
                    end
                    FUNC_MUL:
                    begin
                        prod_next = mul_full;
                    end
                    default:
                    begin
                        if (b_op == 32'sd0)
                            status_next = STAT_DIV_ZERO;
                        dvd_next  = DIV_W'(mag_a) << FRAC_BITS;
                        rem_next  = '0;
                        dvs_next  = mag_b;
                        neg_next  = a_op[31] ^ b_op[31];
                        iter_next = ITER_W'(DIV_W);
                    end
                endcase
            end
            ST_MUL:
            begin
                res_next = mul_shift[31:0];
                if (!((&mul_shift[63:31]) || !(|mul_shift[63:31])))
                begin
                    sat_next = 1'b1;
                    res_next = mul_shift[63] ? Q_MIN : Q_MAX;
                end
            end
            ST_DIV:
            begin
                // Restoring division: one quotient bit per cycle.
                rem_next  = trial_ge ? (trial - {1'b0, dvs_reg}) : trial;
                dvd_next  = {dvd_reg[DIV_W-2:0], trial_ge};
                iter_next = iter_reg - ITER_W'(1);
            end
            ST_DIVFIX:
            begin
                if (neg_reg)
                begin
                    if ((|quot_ext[DIV_W:32]) || (quot_ext[31] && (|quot_ext[30:0])))
                    begin
                        sat_next = 1'b1;
                        res_next = Q_MIN;
                    end
                    else
                        res_next = 32'sd0 - dvd_reg[31:0];
                end
                else
                begin
                    if (|quot_ext[DIV_W:31])
                    begin
                        sat_next = 1'b1;
                        res_next = Q_MAX;
                    end
                    else
                        res_next = dvd_reg[31:0];
                end
            end
            ST_COMMIT:
            begin
                // The result replaces the first operand and becomes the top.
                mem_we     = 1'b1;
                mem_waddr  = cnt_m2[ADDR_W-1:0];
                mem_wdata  = res_reg;
                count_next = count_reg - CNT_W'(1);
                top_next   = res_reg;
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Stack memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= stack_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        func_reg   <= func_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
        res_reg    <= res_next;
        prod_reg   <= prod_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        iter_reg   <= iter_next;
        if (state_reg == ST_FINISH)
        begin
            result_reg.status    <= status_reg;
            result_reg.top_value <= (count_reg == '0) ? 32'sd0 : top_reg;
            result_reg.depth     <= 8'(count_reg);
            result_reg.saturated <= sat_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `RPN_ASSERT_CLK(a_done_after_finish, done_reg |-> $past(state_reg == ST_FINISH),
        "done strobe without a finished transaction")
    `RPN_ASSERT_NEVER(a_count_in_range, count_reg > CNT_W'(STACK_DEPTH),
        "stack count exceeds the stack depth")
    `RPN_ASSERT_CLK(a_exec_has_operands, (state_reg == ST_EXEC) |-> (count_reg >= CNT_W'(2)),
        "binary operation started with fewer than two entries")
    `RPN_ASSERT_CLK(a_count_changes_legally,
        !$stable(count_reg) |-> ($past(state_reg == ST_COMMIT) || $past(accept)),
        "stack count changed outside a push or a commit")

endmodule
